FILE: hw/rtl/urb_pkg.sv
package urb_pkg;

	typedef enum logic [1:0] {
		CMD_RX     = 2'd0,
		CMD_TXDONE = 2'd1,
		CMD_PUT    = 2'd2,
		CMD_GET    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RX_FULL  = 2'd1,
		ST_TX_FULL  = 2'd2,
		ST_RX_EMPTY = 2'd3
	} status_t;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEVEL_W = 5;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

endpackage

FILE: hw/rtl/urb_req_if.sv
interface urb_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  command;
	logic [urb_pkg::BYTE_W-1:0]  data_byte;

	modport source (output valid, command, data_byte, input ready);
	modport sink (input valid, command, data_byte, output ready);
endinterface

FILE: hw/rtl/urb_rsp_if.sv
interface urb_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [urb_pkg::BYTE_W-1:0]  read_byte;
	logic                        send_valid;
	logic [urb_pkg::BYTE_W-1:0]  send_byte;
	logic [urb_pkg::LEVEL_W-1:0] rx_level;
	logic [urb_pkg::LEVEL_W-1:0] tx_room;

	modport source (output valid, status, read_byte, send_valid, send_byte, rx_level, tx_room,
		input ready);
	modport sink (input valid, status, read_byte, send_valid, send_byte, rx_level, tx_room,
		output ready);
endinterface

FILE: hw/rtl/urb_cell.sv
module urb_cell (
	input  logic                       clk,
	input  logic                       shift,
	input  logic                       load,
	input  logic [urb_pkg::BYTE_W-1:0] load_byte,
	input  logic [urb_pkg::BYTE_W-1:0] next_byte,
	output logic [urb_pkg::BYTE_W-1:0] cell_byte
);

	logic [urb_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= next_byte;
		end else if (load) begin
			byte_q <= load_byte;
		end
	end

	assign cell_byte = byte_q;

endmodule

FILE: hw/rtl/urb_queue.sv
module urb_queue #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned LW    = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  urb_pkg::queue_ctl_t        ctl,
	input  logic [urb_pkg::BYTE_W-1:0] push_byte,
	output logic [urb_pkg::BYTE_W-1:0] head_byte,
	output logic [LW-1:0]              level
);

	logic [LW-1:0]              level_q;
	logic [urb_pkg::BYTE_W-1:0] chain [DEPTH+1];

	// cell 0 is the oldest word, a pop moves every cell one step toward it
	assign chain[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		urb_cell u_cell (
			.clk       (clk),
			.shift     (ctl.pop),
			.load      (ctl.push && (level_q == LW'(i))),
			.load_byte (push_byte),
			.next_byte (chain[i+1]),
			.cell_byte (chain[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (ctl.push) begin
			level_q <= level_q + LW'(1);
		end else if (ctl.pop) begin
			level_q <= level_q - LW'(1);
		end
	end

	assign head_byte = chain[0];
	assign level     = level_q;

endmodule

FILE: hw/rtl/uart_rx_tx_ring_buffers_top.sv
// a result word appears in the cycle after its command word is accepted
// throughput: one command word per cycle unless a held result word stalls it, set by
// the update of the receive and transmit cell chains and the output register
// reset clears both queue levels, the transmitter busy flag and the output valid;
// the byte cells are not cleared
module uart_rx_tx_ring_buffers_top #(
	parameter int unsigned RX_DEPTH = 16,
	parameter int unsigned TX_DEPTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	urb_req_if.sink  req,
	urb_rsp_if.source rsp
);

	localparam int unsigned RXW = $clog2(RX_DEPTH + 1);
	localparam int unsigned TXW = $clog2(TX_DEPTH + 1);

	urb_pkg::cmd_t              cmd;
	urb_pkg::status_t           status;
	urb_pkg::queue_ctl_t        rx_ctl;
	urb_pkg::queue_ctl_t        tx_ctl;
	urb_pkg::queue_ctl_t        rx_ctl_a;
	urb_pkg::queue_ctl_t        tx_ctl_a;
	logic                       accept;
	logic                       busy_d;
	logic                       busy_q;
	logic                       sv;
	logic [urb_pkg::BYTE_W-1:0] rd;
	logic [urb_pkg::BYTE_W-1:0] sb;
	logic [urb_pkg::BYTE_W-1:0] rx_head;
	logic [urb_pkg::BYTE_W-1:0] tx_head;
	logic [RXW-1:0]             rx_level;
	logic [TXW-1:0]             tx_level;
	logic [RXW-1:0]             rx_next;
	logic [TXW-1:0]             tx_next;

	logic                        valid_q;
	urb_pkg::status_t            status_q;
	logic [urb_pkg::BYTE_W-1:0]  rd_q;
	logic                        sv_q;
	logic [urb_pkg::BYTE_W-1:0]  sb_q;
	logic [urb_pkg::LEVEL_W-1:0] rx_level_q;
	logic [urb_pkg::LEVEL_W-1:0] tx_room_q;

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cmd       = urb_pkg::cmd_t'(req.command);

	always_comb begin
		status = urb_pkg::ST_OK;
		rd     = '0;
		sv     = 1'b0;
		sb     = '0;
		rx_ctl = '0;
		tx_ctl = '0;
		busy_d = busy_q;
		case (cmd)
			urb_pkg::CMD_RX: begin
				if (rx_level != RXW'(RX_DEPTH)) begin
					rx_ctl.push = 1'b1;
				end else begin
					status = urb_pkg::ST_RX_FULL;
				end
			end
			urb_pkg::CMD_TXDONE: begin
				if (tx_level != '0) begin
					busy_d      = 1'b1;
					sv          = 1'b1;
					sb          = tx_head;
					tx_ctl.pop  = 1'b1;
				end else begin
					busy_d = 1'b0;
				end
			end
			urb_pkg::CMD_PUT: begin
				if (tx_level == TXW'(TX_DEPTH)) begin
					status = urb_pkg::ST_TX_FULL;
				end else if (busy_q) begin
					tx_ctl.push = 1'b1;
				end else begin
					sv     = 1'b1;
					sb     = req.data_byte;
					busy_d = 1'b1;
				end
			end
			urb_pkg::CMD_GET: begin
				if (rx_level == '0) begin
					status = urb_pkg::ST_RX_EMPTY;
				end else begin
					rd         = rx_head;
					rx_ctl.pop = 1'b1;
				end
			end
			default: begin
				status = urb_pkg::ST_OK;
			end
		endcase
	end

	assign rx_ctl_a = accept ? rx_ctl : '0;
	assign tx_ctl_a = accept ? tx_ctl : '0;
	assign rx_next  = rx_level + RXW'(rx_ctl.push) - RXW'(rx_ctl.pop);
	assign tx_next  = tx_level + TXW'(tx_ctl.push) - TXW'(tx_ctl.pop);

	urb_queue #(
		.DEPTH (RX_DEPTH)
	) u_rx_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rx_ctl_a),
		.push_byte (req.data_byte),
		.head_byte (rx_head),
		.level     (rx_level)
	);

	urb_queue #(
		.DEPTH (TX_DEPTH)
	) u_tx_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tx_ctl_a),
		.push_byte (req.data_byte),
		.head_byte (tx_head),
		.level     (tx_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= busy_d;
			end
			if (req.ready) begin
				valid_q <= req.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status;
			rd_q       <= rd;
			sv_q       <= sv;
			sb_q       <= sb;
			rx_level_q <= urb_pkg::LEVEL_W'(rx_next);
			tx_room_q  <= urb_pkg::LEVEL_W'(TXW'(TX_DEPTH) - tx_next);
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_byte  = rd_q;
	assign rsp.send_valid = sv_q;
	assign rsp.send_byte  = sb_q;
	assign rsp.rx_level   = rx_level_q;
	assign rsp.tx_room    = tx_room_q;

endmodule

FILE: bench/uart_rx_tx_ring_buffers_top_tb.sv
module uart_rx_tx_ring_buffers_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RX_SLOTS    = 16;
	localparam int unsigned TX_SLOTS    = 16;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SETTLE      = 10;

	typedef struct packed {
		urb_pkg::status_t              status;
		logic [urb_pkg::BYTE_W-1:0]    read_byte;
		logic                          send_valid;
		logic [urb_pkg::BYTE_W-1:0]    send_byte;
		logic [urb_pkg::LEVEL_W-1:0]   rx_level;
		logic [urb_pkg::LEVEL_W-1:0]   tx_room;
	} queue_report_t;

	logic clk;
	logic arst_n;

	urb_req_if req_bus ();
	urb_rsp_if rsp_bus ();

	uart_rx_tx_ring_buffers_top #(
		.RX_DEPTH(RX_SLOTS),
		.TX_DEPTH(TX_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	// shadow copy of both queues
	logic [urb_pkg::BYTE_W-1:0] rx_mem [RX_SLOTS];
	logic [urb_pkg::BYTE_W-1:0] tx_mem [TX_SLOTS];
	int unsigned                rx_head;
	int unsigned                rx_fill;
	int unsigned                tx_head;
	int unsigned                tx_fill;
	logic                       tx_active;

	queue_report_t pending_reports [$];
	int unsigned   error_count;
	int unsigned   cycle_count;
	bit            quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic queue_report_t apply_event(urb_pkg::cmd_t cmd,
		logic [urb_pkg::BYTE_W-1:0] data);
		queue_report_t rep;
		rep = '0;
		rep.status = urb_pkg::ST_OK;
		case (cmd)
			urb_pkg::CMD_RX: begin
				if (rx_fill < RX_SLOTS) begin
					rx_mem[(rx_head + rx_fill) % RX_SLOTS] = data;
					rx_fill++;
				end else begin
					rep.status = urb_pkg::ST_RX_FULL;
				end
			end
			urb_pkg::CMD_TXDONE: begin
				if (tx_fill != 0) begin
					tx_active = 1'b1;
					rep.send_valid = 1'b1;
					rep.send_byte = tx_mem[tx_head];
					tx_fill--;
					tx_head = (tx_head + 1) % TX_SLOTS;
				end else begin
					tx_active = 1'b0;
				end
			end
			urb_pkg::CMD_PUT: begin
				if (tx_fill >= TX_SLOTS) begin
					rep.status = urb_pkg::ST_TX_FULL;
				end else if (tx_active) begin
					tx_mem[(tx_head + tx_fill) % TX_SLOTS] = data;
					tx_fill++;
				end else begin
					rep.send_valid = 1'b1;
					rep.send_byte = data;
					tx_active = 1'b1;
				end
			end
			default: begin
				if (rx_fill == 0) begin
					rep.status = urb_pkg::ST_RX_EMPTY;
				end else begin
					rep.read_byte = rx_mem[rx_head];
					rx_fill--;
					rx_head = (rx_head + 1) % RX_SLOTS;
				end
			end
		endcase
		rep.rx_level = rx_fill[urb_pkg::LEVEL_W-1:0];
		rep.tx_room = urb_pkg::LEVEL_W'(TX_SLOTS - tx_fill);
		return rep;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// accepted command words feed the predictor, result words are checked
	always @(posedge clk) begin
		queue_report_t exp_rep;
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready)
				pending_reports.push_back(apply_event(urb_pkg::cmd_t'(req_bus.command),
					req_bus.data_byte));
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (pending_reports.size() == 0) begin
					$error("result word with nothing expected");
					error_count++;
				end else begin
					exp_rep = pending_reports.pop_front();
					if (rsp_bus.status !== exp_rep.status) begin
						$error("status expected %0d got %0d", exp_rep.status, rsp_bus.status);
						error_count++;
					end
					if (rsp_bus.read_byte !== exp_rep.read_byte) begin
						$error("read_byte expected %0h got %0h", exp_rep.read_byte,
							rsp_bus.read_byte);
						error_count++;
					end
					if (rsp_bus.send_valid !== exp_rep.send_valid) begin
						$error("send_valid expected %0d got %0d", exp_rep.send_valid,
							rsp_bus.send_valid);
						error_count++;
					end
					if (rsp_bus.send_byte !== exp_rep.send_byte) begin
						$error("send_byte expected %0h got %0h", exp_rep.send_byte,
							rsp_bus.send_byte);
						error_count++;
					end
					if (rsp_bus.rx_level !== exp_rep.rx_level) begin
						$error("rx_level expected %0d got %0d", exp_rep.rx_level,
							rsp_bus.rx_level);
						error_count++;
					end
					if (rsp_bus.tx_room !== exp_rep.tx_room) begin
						$error("tx_room expected %0d got %0d", exp_rep.tx_room,
							rsp_bus.tx_room);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				rsp_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_bus.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_word(urb_pkg::cmd_t cmd, logic [urb_pkg::BYTE_W-1:0] data);
		int unsigned gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_bus.valid <= 1'b0;
		end
		@(negedge clk);
		req_bus.valid <= 1'b1;
		req_bus.command <= cmd;
		req_bus.data_byte <= data;
		do
			@(posedge clk);
		while (!req_bus.ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(urb_pkg::CMD_GET, 8'hFF);
		send_word(urb_pkg::CMD_TXDONE, 8'h00);
		send_word(urb_pkg::CMD_RX, 8'h00);
		send_word(urb_pkg::CMD_RX, 8'hFF);
		send_word(urb_pkg::CMD_GET, 8'h00);
		send_word(urb_pkg::CMD_GET, 8'hFF);
		send_word(urb_pkg::CMD_GET, 8'h00);
		send_word(urb_pkg::CMD_PUT, 8'hFF);
		send_word(urb_pkg::CMD_PUT, 8'h00);
		send_word(urb_pkg::CMD_PUT, 8'hA5);
		send_word(urb_pkg::CMD_TXDONE, 8'hFF);
		send_word(urb_pkg::CMD_TXDONE, 8'h00);
		send_word(urb_pkg::CMD_TXDONE, 8'h5A);
		send_word(urb_pkg::CMD_PUT, 8'h5A);
		send_word(urb_pkg::CMD_RX, 8'h81);
		send_word(urb_pkg::CMD_TXDONE, 8'h00);
		send_word(urb_pkg::CMD_GET, 8'h7E);
		wait_drained();
	endtask

	// fill and drain the receive queue, past full and past empty
	task automatic test_rx_bursts();
		int unsigned n;
		for (int round = 0; round < 22; round++) begin
			quiet = ($urandom_range(0, 3) == 0);
			n = $urandom_range(0, 20);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_word(($urandom_range(0, 1) == 0) ? urb_pkg::CMD_TXDONE :
						urb_pkg::CMD_PUT, 8'($urandom));
				else
					send_word(urb_pkg::CMD_RX, 8'($urandom));
			end
			n = $urandom_range(0, 20);
			repeat (n)
				send_word(urb_pkg::CMD_GET, 8'($urandom));
		end
		quiet = 1'b0;
	endtask

	// queue puts behind a busy transmitter until full, then let it drain
	task automatic test_tx_bursts();
		int unsigned n;
		for (int round = 0; round < 22; round++) begin
			quiet = ($urandom_range(0, 3) == 0);
			n = $urandom_range(0, 20);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_word(($urandom_range(0, 1) == 0) ? urb_pkg::CMD_RX :
						urb_pkg::CMD_GET, 8'($urandom));
				else
					send_word(urb_pkg::CMD_PUT, 8'($urandom));
			end
			n = $urandom_range(0, 20);
			repeat (n)
				send_word(urb_pkg::CMD_TXDONE, 8'($urandom));
		end
		quiet = 1'b0;
	endtask

	task automatic test_mixed();
		for (int i = 0; i < 650; i++) begin
			if (i % 130 == 129) begin
				wait_drained();
				quiet = ~quiet;
			end
			send_word(urb_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		quiet = 1'b0;
		error_count = 0;
		cycle_count = 0;
		rx_head = 0;
		rx_fill = 0;
		tx_head = 0;
		tx_fill = 0;
		tx_active = 1'b0;
		for (int i = 0; i < RX_SLOTS; i++)
			rx_mem[i] = '0;
		for (int i = 0; i < TX_SLOTS; i++)
			tx_mem[i] = '0;
		req_bus.valid = 1'b0;
		req_bus.command = urb_pkg::CMD_RX;
		req_bus.data_byte = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_rx_bursts();
		test_tx_bursts();
		test_mixed();

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
